FILE: sv/dpb_pkg.sv
// ----------------------------------------------------------------------------
// dpb_pkg
// shared types, constants and helpers of the depth pixel back-projection block
// ----------------------------------------------------------------------------
package dpb_pkg;

  localparam int unsigned MAX_DIM   = 4096;
  localparam int unsigned CNT_W     = 12;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned ITER_W    = 6;
  localparam logic [5:0]  ITER_Z    = 6'd32;
  localparam logic [5:0]  ITER_XY   = 6'd48;

  localparam logic [2:0] REG_DEPTH_SCALE  = 3'd0;
  localparam logic [2:0] REG_CENTER_X     = 3'd1;
  localparam logic [2:0] REG_CENTER_Y     = 3'd2;
  localparam logic [2:0] REG_FOCAL_X      = 3'd3;
  localparam logic [2:0] REG_FOCAL_Y      = 3'd4;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd5;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd6;

  typedef struct packed {
    logic [15:0] depth_scale;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] focal_x;
    logic [15:0] focal_y;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic start_z;
    logic start_x;
    logic start_y;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } sts_t;

  function automatic logic [12:0] eff_dim(input logic [12:0] v);
    logic [12:0] r;
    r = v;
    if (v == 13'd0) r = 13'd1;
    else if (v > 13'(MAX_DIM)) r = 13'(MAX_DIM);
    return r;
  endfunction

  function automatic logic [15:0] eff_div(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  // magnitude quotient to signed 48 bits, saturated
  function automatic logic [47:0] sat48(input logic [47:0] q, input logic neg);
    logic [47:0] r;
    if (neg) begin
      r = (q > 48'h8000_0000_0000) ? 48'h8000_0000_0000 : (48'd0 - q);
    end else begin
      r = q[47] ? 48'h7FFF_FFFF_FFFF : q;
    end
    return r;
  endfunction

endpackage

FILE: sv/dpb_regs.sv
// ----------------------------------------------------------------------------
// dpb_regs
// configuration register file behind the apb-style port
// ----------------------------------------------------------------------------
module dpb_regs
  import dpb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t        cfg_q;
  logic        wr_en;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_scale  <= 16'd1000;
      cfg_q.center_x     <= 16'd5120;
      cfg_q.center_y     <= 16'd3840;
      cfg_q.focal_x      <= 16'd8400;
      cfg_q.focal_y      <= 16'd8400;
      cfg_q.image_width  <= 13'd640;
      cfg_q.image_height <= 13'd480;
    end else if (wr_en) begin
      case (idx)
        REG_DEPTH_SCALE:  cfg_q.depth_scale  <= pwdata[15:0];
        REG_CENTER_X:     cfg_q.center_x     <= pwdata[15:0];
        REG_CENTER_Y:     cfg_q.center_y     <= pwdata[15:0];
        REG_FOCAL_X:      cfg_q.focal_x      <= pwdata[15:0];
        REG_FOCAL_Y:      cfg_q.focal_y      <= pwdata[15:0];
        REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[12:0];
        REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEPTH_SCALE:  prdata = {16'd0, cfg_q.depth_scale};
      REG_CENTER_X:     prdata = {16'd0, cfg_q.center_x};
      REG_CENTER_Y:     prdata = {16'd0, cfg_q.center_y};
      REG_FOCAL_X:      prdata = {16'd0, cfg_q.focal_x};
      REG_FOCAL_Y:      prdata = {16'd0, cfg_q.focal_y};
      REG_IMAGE_WIDTH:  prdata = {19'd0, cfg_q.image_width};
      REG_IMAGE_HEIGHT: prdata = {19'd0, cfg_q.image_height};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

FILE: sv/dpb_ctrl.sv
// ----------------------------------------------------------------------------
// dpb_ctrl
// sequencer: z division, then x and y divisions, then result hand-off
// ----------------------------------------------------------------------------
module dpb_ctrl
  import dpb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIVZ = 2'd1;
  localparam logic [1:0] S_DIVX = 2'd2;
  localparam logic [1:0] S_DIVY = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start_z = 1'b1;
          state_d       = S_DIVZ;
        end
      end
      S_DIVZ: begin
        if (!sts_i.div_busy) begin
          cmd_o.start_x = 1'b1;
          state_d       = S_DIVX;
        end
      end
      S_DIVX: begin
        if (!sts_i.div_busy) begin
          cmd_o.start_y = 1'b1;
          state_d       = S_DIVY;
        end
      end
      S_DIVY: begin
        if (!sts_i.div_busy && sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/dpb_datapath.sv
// ----------------------------------------------------------------------------
// dpb_datapath
// pixel counters, shared restoring divider with input multiplier, output register
// ----------------------------------------------------------------------------
module dpb_datapath
  import dpb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [15:0]        depth_i,
  input  logic [23:0]        color_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [47:0] point_x_o,
  output logic signed [47:0] point_y_o,
  output logic [31:0]        point_z_o,
  output logic [23:0]        color_out_o,
  output logic [11:0]        pixel_col_o,
  output logic [11:0]        pixel_row_o,
  output logic               frame_end_o
);

  logic [CNT_W-1:0] col_q, row_q;
  logic [CNT_W-1:0] item_col_q, item_row_q;
  logic             item_end_q;
  logic [23:0]      color_q;
  logic [31:0]      z_q;
  logic [47:0]      x_q;

  logic [47:0]       dvd_q;
  logic [15:0]       rem_q, div_q;
  logic [ITER_W-1:0] cnt_q;
  logic              div_busy;
  logic [16:0]       trial;
  logic              fits;

  logic        out_valid_q;
  logic [47:0] out_x_q, out_y_q;
  logic [31:0] out_z_q;
  logic [23:0] out_color_q;
  logic [11:0] out_col_q, out_row_q;
  logic        out_end_q;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic             row_last, frame_last;
  logic [15:0]      px, py, mag_x, mag_y;
  logic             neg_x, neg_y;
  logic [31:0]      z_now;

  assign w_eff      = eff_dim(cfg_i.image_width);
  assign h_eff      = eff_dim(cfg_i.image_height);
  assign row_last   = ({1'b0, col_q} + 13'd1) >= w_eff;
  assign frame_last = row_last && (({1'b0, row_q} + 13'd1) >= h_eff);

  // offsets from the principal point, Q.4
  assign px    = {item_col_q, 4'd0};
  assign py    = {item_row_q, 4'd0};
  assign neg_x = px < cfg_i.center_x;
  assign neg_y = py < cfg_i.center_y;
  assign mag_x = neg_x ? (cfg_i.center_x - px) : (px - cfg_i.center_x);
  assign mag_y = neg_y ? (cfg_i.center_y - py) : (py - cfg_i.center_y);
  assign z_now = dvd_q[31:0];

  assign div_busy = (cnt_q != '0);
  assign trial    = {rem_q, dvd_q[47]};
  assign fits     = trial >= {1'b0, div_q};

  assign sts_o.div_busy = div_busy;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // pixel counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.start_z) begin
      if (row_last) begin
        col_q <= '0;
        row_q <= frame_last ? '0 : row_q + 12'd1;
      end else begin
        col_q <= col_q + 12'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_z) begin
      item_col_q <= col_q;
      item_row_q <= row_q;
      item_end_q <= frame_last;
      color_q    <= color_i;
    end
    if (cmd_i.start_x) begin
      z_q <= z_now;
    end
    if (cmd_i.start_y) begin
      x_q <= sat48(dvd_q, neg_x);
    end
  end

  // one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.start_z) begin
      cnt_q <= ITER_Z;
    end else if (cmd_i.start_x || cmd_i.start_y) begin
      cnt_q <= ITER_XY;
    end else if (div_busy) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_z) begin
      dvd_q <= {depth_i, 32'd0};
      div_q <= eff_div(cfg_i.depth_scale);
      rem_q <= '0;
    end else if (cmd_i.start_x) begin
      dvd_q <= 48'(mag_x) * 48'(z_now);
      div_q <= eff_div(cfg_i.focal_x);
      rem_q <= '0;
    end else if (cmd_i.start_y) begin
      dvd_q <= 48'(mag_y) * 48'(z_q);
      div_q <= eff_div(cfg_i.focal_y);
      rem_q <= '0;
    end else if (div_busy) begin
      dvd_q <= {dvd_q[46:0], fits};
      rem_q <= fits ? 16'(trial - {1'b0, div_q}) : trial[15:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_x_q     <= x_q;
      out_y_q     <= sat48(dvd_q, neg_y);
      out_z_q     <= z_q;
      out_color_q <= color_q;
      out_col_q   <= item_col_q;
      out_row_q   <= item_row_q;
      out_end_q   <= item_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_x_o   = out_x_q;
  assign point_y_o   = out_y_q;
  assign point_z_o   = out_z_q;
  assign color_out_o = out_color_q;
  assign pixel_col_o = out_col_q;
  assign pixel_row_o = out_row_q;
  assign frame_end_o = out_end_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.start_z || cmd_i.start_x || cmd_i.start_y) |-> !div_busy)
    else $error("divider started while busy");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.start_z || cmd_i.start_x || cmd_i.start_y) |=> div_busy)
    else $error("divider did not start");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!div_busy && (!out_valid_q || !out_stall_i)))
    else $error("result loaded over a pending transfer");

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.load_out))
    else $error("result valid without load");

endmodule

FILE: sv/depth_pixel_backprojection.sv
// ----------------------------------------------------------------------------
// depth_pixel_backprojection
// pinhole back-projection of a raster depth stream into camera-frame points
// ----------------------------------------------------------------------------
// order: the z division, then the x and y divisions on the one radix-2 divider,
//   then a hand-over of the result into the output register
// pixels: one at a time, held by the shared divider; the next pixel
//   is taken while a finished result waits in the output register
// reset: counters clear to zero, registers take their documented defaults
module depth_pixel_backprojection
  import dpb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        depth_i,
  input  logic [23:0]        color_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [47:0] point_x_o,
  output logic signed [47:0] point_y_o,
  output logic [31:0]        point_z_o,
  output logic [23:0]        color_out_o,
  output logic [11:0]        pixel_col_o,
  output logic [11:0]        pixel_row_o,
  output logic               frame_end_o
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  dpb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dpb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dpb_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .depth_i     (depth_i),
    .color_i     (color_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o),
    .point_z_o   (point_z_o),
    .color_out_o (color_out_o),
    .pixel_col_o (pixel_col_o),
    .pixel_row_o (pixel_row_o),
    .frame_end_o (frame_end_o)
  );

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// random and directed pixel streams through the back-projection block; a
// scoreboard predicts each point from its own counters and configuration
// ----------------------------------------------------------------------------
class point_scoreboard;
  logic [15:0] depth_scale, center_x, center_y, focal_x, focal_y;
  logic [12:0] image_width, image_height;
  logic [11:0] col_cnt, row_cnt;
  logic [47:0] q_x[$], q_y[$];
  logic [31:0] q_z[$];
  logic [23:0] q_col[$];
  logic [11:0] q_pc[$], q_pr[$];
  logic        q_fe[$];
  int          errors;

  function new();
    depth_scale = 1000; center_x = 5120; center_y = 3840;
    focal_x = 8400; focal_y = 8400; image_width = 640; image_height = 480;
    col_cnt = 0; row_cnt = 0; errors = 0;
  endfunction

  function void set_reg(int idx, logic [31:0] v);
    case (idx)
      dpb_pkg::REG_DEPTH_SCALE:  depth_scale = v[15:0];
      dpb_pkg::REG_CENTER_X:     center_x = v[15:0];
      dpb_pkg::REG_CENTER_Y:     center_y = v[15:0];
      dpb_pkg::REG_FOCAL_X:      focal_x = v[15:0];
      dpb_pkg::REG_FOCAL_Y:      focal_y = v[15:0];
      dpb_pkg::REG_IMAGE_WIDTH:  image_width = v[12:0];
      dpb_pkg::REG_IMAGE_HEIGHT: image_height = v[12:0];
      default: ;
    endcase
  endfunction

  function logic [47:0] project(logic [11:0] pos, logic [15:0] ctr, logic [15:0] foc,
                                logic [31:0] z);
    logic [17:0] p, mag;
    logic        neg;
    logic [63:0] q;
    p = 18'({pos, 4'd0});
    neg = p < 18'(ctr);
    mag = neg ? (18'(ctr) - p) : (p - 18'(ctr));
    q = (64'(mag) * 64'(z)) / 64'((foc == 0) ? 16'd1 : foc);
    if (neg) return (q > 64'h8000_0000_0000) ? 48'h8000_0000_0000 : 48'd0 - q[47:0];
    return (q > 64'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : q[47:0];
  endfunction

  function void note_pixel(logic [15:0] depth, logic [23:0] color);
    logic [31:0] z, w, h;
    logic        row_last, frame_last;
    z = 32'((64'(depth) << 16) / 64'((depth_scale == 0) ? 16'd1 : depth_scale));
    w = (image_width == 0) ? 1 : (image_width > 4096) ? 4096 : image_width;
    h = (image_height == 0) ? 1 : (image_height > 4096) ? 4096 : image_height;
    row_last = (32'(col_cnt) + 1) >= w;
    frame_last = row_last && (32'(row_cnt) + 1) >= h;
    q_x.insert(q_x.size(), project(col_cnt, center_x, focal_x, z));
    q_y.insert(q_y.size(), project(row_cnt, center_y, focal_y, z));
    q_z.insert(q_z.size(), z); q_col.insert(q_col.size(), color);
    q_pc.insert(q_pc.size(), col_cnt); q_pr.insert(q_pr.size(), row_cnt);
    q_fe.insert(q_fe.size(), frame_last);
    if (row_last) begin
      col_cnt = '0;
      row_cnt = frame_last ? 12'd0 : row_cnt + 12'd1;
    end else begin
      col_cnt = col_cnt + 12'd1;
    end
  endfunction

  function void check_point(logic [47:0] x, logic [47:0] y, logic [31:0] z,
                            logic [23:0] c, logic [11:0] pc, logic [11:0] pr,
                            logic fe);
    if (q_z.size() == 0) begin
      $display("%0t: unexpected point, expected none, got z %h", $time, z);
      errors++;
      return;
    end
    if (q_x[0] !== x) begin
      $display("%0t: point_x expected %h got %h", $time, q_x[0], x); errors++;
    end
    if (q_y[0] !== y) begin
      $display("%0t: point_y expected %h got %h", $time, q_y[0], y); errors++;
    end
    if (q_z[0] !== z) begin
      $display("%0t: point_z expected %h got %h", $time, q_z[0], z); errors++;
    end
    if (q_col[0] !== c) begin
      $display("%0t: color expected %h got %h", $time, q_col[0], c); errors++;
    end
    if (q_pc[0] !== pc) begin
      $display("%0t: col expected %0d got %0d", $time, q_pc[0], pc); errors++;
    end
    if (q_pr[0] !== pr) begin
      $display("%0t: row expected %0d got %0d", $time, q_pr[0], pr); errors++;
    end
    if (q_fe[0] !== fe) begin
      $display("%0t: frame_end expected %b got %b", $time, q_fe[0], fe); errors++;
    end
    void'(q_x.pop_front()); void'(q_y.pop_front()); void'(q_z.pop_front());
    void'(q_col.pop_front()); void'(q_pc.pop_front()); void'(q_pr.pop_front());
    void'(q_fe.pop_front());
  endfunction

  function int pending();
    return q_z.size();
  endfunction
endclass

module testbench
  import dpb_pkg::*;
;

  logic               clk_i = 0, rst_ni = 0;
  logic               psel = 0, penable = 0, pwrite = 0;
  logic [4:0]         paddr = 0;
  logic [31:0]        pwdata = 0, prdata;
  logic               pready;
  logic               in_valid_i = 0, in_stall_o;
  logic [15:0]        depth_i = 0;
  logic [23:0]        color_i = 0;
  logic               out_valid_o, out_stall_i = 0;
  logic signed [47:0] point_x_o, point_y_o;
  logic [31:0]        point_z_o;
  logic [23:0]        color_out_o;
  logic [11:0]        pixel_col_o, pixel_row_o;
  logic               frame_end_o;
  logic               calm = 0;
  longint             cycles = 0;
  point_scoreboard    sb = new();

  depth_pixel_backprojection DUT (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2_000_000) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_point(point_x_o, point_y_o, point_z_o, color_out_o, pixel_col_o,
                     pixel_row_o, frame_end_o);
  end

  // receiver stalls in bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        out_stall_i <= 0;
      end
    end
  end

  task automatic write_reg(int idx, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= 5'(4 * idx); pwdata <= v;
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // valid stays up between back-to-back transfers but for random gaps; drain drops it
  task automatic send_pixel(logic [15:0] d, logic [23:0] c);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i <= 1; depth_i <= d; color_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_pixel(d, c);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_all(logic [15:0] ds, logic [15:0] cx, logic [15:0] cy,
                         logic [15:0] fx, logic [15:0] fy, logic [12:0] w, logic [12:0] h);
    write_reg(REG_DEPTH_SCALE, 32'(ds));  write_reg(REG_CENTER_X, 32'(cx));
    write_reg(REG_CENTER_Y, 32'(cy));     write_reg(REG_FOCAL_X, 32'(fx));
    write_reg(REG_FOCAL_Y, 32'(fy));      write_reg(REG_IMAGE_WIDTH, 32'(w));
    write_reg(REG_IMAGE_HEIGHT, 32'(h));
  endtask

  function automatic logic [15:0] rnd_depth();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 3));
      1: return 16'hFFFF - 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1;
    // directed: reset config, depth extremes, colour extremes
    send_pixel(16'd0, 24'h000000);
    send_pixel(16'hFFFF, 24'hFFFFFF);
    send_pixel(16'd1, 24'hA5A5A5);
    drain();
    // tiny frames with scale 1 and focal 1 to force saturation; out-of-range sizes
    set_all(16'd1, 16'd0, 16'hFFFF, 16'd1, 16'd1, 13'd3, 13'd2);
    for (int i = 0; i < 8; i++) send_pixel(16'hFFFF, 24'($urandom));
    drain();
    set_all(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 13'd0, 13'd0);
    for (int i = 0; i < 3; i++) send_pixel(16'hFFFF, 24'($urandom));
    drain();
    // width above limit, then shrink mid-row so the counter sits beyond the end
    set_all(16'hFFFF, 16'd40, 16'd20, 16'hFFFF, 16'd3, 13'd8191, 13'd4096);
    for (int i = 0; i < 5; i++) send_pixel(rnd_depth(), 24'($urandom));
    drain();
    write_reg(REG_IMAGE_WIDTH, 32'd2);
    write_reg(REG_IMAGE_HEIGHT, 32'd1);
    for (int i = 0; i < 4; i++) send_pixel(rnd_depth(), 24'($urandom));
    drain();
    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      set_all(16'($urandom_range(0, 65535)), 16'($urandom), 16'($urandom),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              13'($urandom_range(0, 12)), 13'($urandom_range(0, 6)));
      if (ph == 7) calm = 1;
      for (int i = 0; i < 250; i++) send_pixel(rnd_depth(), 24'($urandom));
      drain();
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
